>>> sv/pced_pkg.sv
// Shared types and constants for the pin-change event dispatcher.
// Depends on nothing; the top level, the controller and the datapath import it.
package pced_pkg;

	// Operation codes carried on the op field of an input request.
	localparam logic OP_SAMPLE   = 1'b0;
	localparam logic OP_REGISTER = 1'b1;

	// An event id of all ones marks a pin that raises no event.
	localparam logic [7:0] SILENT_ID = 8'hFF;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;    // take the input request this cycle
		logic issue;     // read the id of the lowest pending bit and retire it
		logic load_out;  // move the id read into the output register
	} pced_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic sample_start;  // the offered request is a sample of a valid group
		logic pending_any;   // changed pins of the current sample remain
	} pced_status_t;

endpackage

>>> sv/pin_change_event_dispatcher.sv
// Top level of the pin-change event dispatcher.
// Depends on pced_pkg, pced_ctrl and pced_datapath.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request: op selects a
//   register request (pin_index, pin_id, port_value) or a port sample
//   (group, port_value). Output channel (out_valid/out_ready) carries one
//   event per changed, watched, non-silent pin: event_id, level and last,
//   which marks the final event of a sample.
//   A register request is taken in the idle state and leaves the block idle.
//   A sample that raises no event goes through the scan state only; for
//   each event the block passes a scan state, a read of the id RAM through
//   its single registered read port, and the output register. Requests are
//   accepted only while no sample is in progress.
//   A stalled receiver holds the current event in the output register and
//   the block waits with it; nothing is lost.
//   Reset clears all levels, watch masks and first-registration flags; the
//   id store needs no clearing, so the block is ready straight after reset.
module pin_change_event_dispatcher
	import pced_pkg::*;
#(
	parameter int NUM_GROUPS     = 3,
	parameter int PINS_PER_GROUP = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       op,
	input  logic [1:0] group,
	input  logic [7:0] port_value,
	input  logic [4:0] pin_index,
	input  logic [7:0] pin_id,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] event_id,
	output logic       level,
	output logic       last
);

	pced_cmd_t    cmd;
	pced_status_t status;

	// Sequencer.
	pced_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// State, id store and output register.
	pced_datapath #(
		.NUM_GROUPS     (NUM_GROUPS),
		.PINS_PER_GROUP (PINS_PER_GROUP)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.op         (op),
		.group      (group),
		.port_value (port_value),
		.pin_index  (pin_index),
		.pin_id     (pin_id),
		.event_id   (event_id),
		.level      (level),
		.last       (last)
	);

endmodule

>>> sv/pced_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module pced_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 24
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> sv/pced_datapath.sv
// Datapath of the pin-change event dispatcher: per-group levels, watch masks,
// silent flags, the id RAM and the output register. Uses pced_pkg and pced_ram.
module pced_datapath
	import pced_pkg::*;
#(
	parameter int NUM_GROUPS     = 3,
	parameter int PINS_PER_GROUP = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  pced_cmd_t    cmd,
	output pced_status_t status,
	input  logic         op,
	input  logic [1:0]   group,
	input  logic [7:0]   port_value,
	input  logic [4:0]   pin_index,
	input  logic [7:0]   pin_id,
	output logic [7:0]   event_id,
	output logic         level,
	output logic         last
);

	localparam int PW    = PINS_PER_GROUP;
	localparam int BW    = (PINS_PER_GROUP > 1) ? $clog2(PINS_PER_GROUP) : 1;
	localparam int GW    = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
	localparam int TOTAL = NUM_GROUPS * PINS_PER_GROUP;
	localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;

	logic [7:0]    prev_q   [NUM_GROUPS];
	logic [PW-1:0] mask_q   [NUM_GROUPS];
	logic [PW-1:0] silent_q [NUM_GROUPS];
	logic [NUM_GROUPS-1:0] seeded_q;

	logic [GW-1:0] grp_q;
	logic [PW-1:0] port_q;
	logic [PW-1:0] pending_q;
	logic          level_q;
	logic          last_q;
	logic [7:0]    event_id_q;
	logic          level_out_q;
	logic          last_out_q;

	logic          reg_hit;
	logic [GW-1:0] reg_grp;
	logic [BW-1:0] reg_bit;
	logic [PW-1:0] reg_onehot;
	logic          smp_hit;
	logic [GW-1:0] smp_grp;
	logic [PW-1:0] changed;
	logic [BW-1:0] low_bit;
	logic [PW-1:0] pending_next;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	// Split the pin index into group and bit by range compares.
	always_comb begin
		reg_hit = 1'b0;
		reg_grp = '0;
		reg_bit = '0;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			if (32'(pin_index) >= g * PINS_PER_GROUP &&
			    32'(pin_index) < (g + 1) * PINS_PER_GROUP) begin
				reg_hit = 1'b1;
				reg_grp = GW'(g);
				reg_bit = BW'(32'(pin_index) - g * PINS_PER_GROUP);
			end
		end
	end

	assign reg_onehot = PW'(1) << reg_bit;

	// Sample decode and the watched, non-silent bits that changed.
	assign smp_hit = (32'(group) < NUM_GROUPS);
	assign smp_grp = GW'(group);
	assign changed = (port_value[PW-1:0] ^ prev_q[smp_grp][PW-1:0])
	                 & mask_q[smp_grp] & ~silent_q[smp_grp];

	assign status.sample_start = (op == OP_SAMPLE) && smp_hit;
	assign status.pending_any  = (pending_q != '0);

	// Lowest pending bit, and the pending set once it is retired.
	always_comb begin
		low_bit = '0;
		for (int b = PW - 1; b >= 0; b--) begin
			if (pending_q[b]) begin
				low_bit = BW'(b);
			end
		end
	end

	assign pending_next = pending_q & (pending_q - PW'(1));

	// Per-group state: levels, masks and first-registration flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < NUM_GROUPS; g++) begin
				prev_q[g] <= '0;
				mask_q[g] <= '0;
			end
			seeded_q <= '0;
		end else if (cmd.accept) begin
			if (op == OP_REGISTER) begin
				if (reg_hit) begin
					seeded_q[reg_grp] <= 1'b1;
					if (!seeded_q[reg_grp]) begin
						prev_q[reg_grp] <= port_value;
						mask_q[reg_grp] <= reg_onehot;
					end else begin
						mask_q[reg_grp] <= mask_q[reg_grp] | reg_onehot;
					end
				end
			end else if (smp_hit) begin
				prev_q[smp_grp] <= port_value;
			end
		end
	end

	// Silent flags follow the id written; they are read only where watched.
	always_ff @(posedge clk) begin
		if (cmd.accept && op == OP_REGISTER && reg_hit) begin
			silent_q[reg_grp][reg_bit] <= (pin_id == SILENT_ID);
		end
	end

	// Pending set of the sample in progress.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (cmd.accept && status.sample_start) begin
			pending_q <= changed;
		end else if (cmd.issue) begin
			pending_q <= pending_next;
		end
	end

	// Sample context and the level and last flag of the event being read.
	always_ff @(posedge clk) begin
		if (cmd.accept && status.sample_start) begin
			grp_q  <= smp_grp;
			port_q <= port_value[PW-1:0];
		end
		if (cmd.issue) begin
			level_q <= port_q[low_bit];
			last_q  <= (pending_next == '0);
		end
		if (cmd.load_out) begin
			event_id_q  <= ram_rdata;
			level_out_q <= level_q;
			last_out_q  <= last_q;
		end
	end

	// Id store, written by register requests and read one pin at a time.
	assign ram_we    = cmd.accept && (op == OP_REGISTER) && reg_hit;
	assign ram_waddr = AW'(32'(reg_grp) * PINS_PER_GROUP + 32'(reg_bit));
	assign ram_raddr = AW'(32'(grp_q) * PINS_PER_GROUP + 32'(low_bit));

	pced_ram #(
		.WIDTH (8),
		.DEPTH (TOTAL)
	) u_id_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (pin_id),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign event_id = event_id_q;
	assign level    = level_out_q;
	assign last     = last_out_q;

	// An id is read only while a changed pin is still pending.
	a_issue_pending: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> pending_q != '0)
		else $error("event issued with nothing pending");

	// Each issue retires exactly one pending pin.
	a_issue_retires_one: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |=> $countones(pending_q) == $countones($past(pending_q)) - 1)
		else $error("issue did not retire exactly one pin");

endmodule

>>> sv/pced_ctrl.sv
// Controller of the pin-change event dispatcher: accepts requests and steps
// through the changed pins of a sample. Uses pced_pkg.
module pced_ctrl
	import pced_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	input  pced_status_t status,
	output pced_cmd_t    cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_LOAD = 2'd2;
	localparam logic [1:0] S_HOLD = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// Next state and commands.
	always_comb begin
		state_d      = state_q;
		cmd.accept   = 1'b0;
		cmd.issue    = 1'b0;
		cmd.load_out = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = status.sample_start ? S_SCAN : S_IDLE;
				end
			end
			S_SCAN: begin
				if (status.pending_any) begin
					cmd.issue = 1'b1;
					state_d   = S_LOAD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_LOAD: begin
				cmd.load_out = 1'b1;
				state_d      = S_HOLD;
			end
			S_HOLD: begin
				if (out_ready) begin
					state_d = status.pending_any ? S_SCAN : S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_HOLD);

	// Input and output sides are never open at once.
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output handshakes open together");

	// A loaded event is always presented next.
	a_load_then_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOAD |=> out_valid)
		else $error("loaded event not presented");

	// A presented event is held until it is taken.
	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("event dropped while stalled");

endmodule
